### rtl/lcib_pkg.sv
// ----------------------------------------------------------------------------
// lcib_pkg: shared definitions for the LANCE-style CSR and interrupt block
// Bit positions of CSR0, request kinds, bus register targets and outcome
// codes.
// ----------------------------------------------------------------------------
package lcib_pkg;

	// CSR0 bit positions
	localparam int unsigned CSR0_ERR  = 15;
	localparam int unsigned CSR0_RINT = 10;
	localparam int unsigned CSR0_TINT = 9;
	localparam int unsigned CSR0_IDON = 8;
	localparam int unsigned CSR0_INTR = 7;
	localparam int unsigned CSR0_INEA = 6;
	localparam int unsigned CSR0_RXON = 5;
	localparam int unsigned CSR0_TXON = 4;
	localparam int unsigned CSR0_TDMD = 3;
	localparam int unsigned CSR0_STOP = 2;
	localparam int unsigned CSR0_STRT = 1;
	localparam int unsigned CSR0_INIT = 0;

	localparam logic [15:0] CSR0_W1C_MASK = 16'h8700;  // ERR|RINT|TINT|IDON
	localparam logic [15:0] CSR0_RESET    = 16'h0004;  // STOP only

	typedef logic [15:0] csr_t;
	typedef logic [31:0] count_t;

	// request kind
	localparam logic [2:0] FN_BUS_WRITE = 3'd0;
	localparam logic [2:0] FN_INIT_DONE = 3'd1;
	localparam logic [2:0] FN_RX_DONE   = 3'd2;
	localparam logic [2:0] FN_TX_DONE   = 3'd3;
	localparam logic [2:0] FN_BUS_RESET = 3'd4;

	// bus write target
	localparam logic [1:0] REG_RDP = 2'd0;
	localparam logic [1:0] REG_RAP = 2'd1;
	localparam logic [1:0] REG_RST = 2'd2;

	// CSR selected by RAP
	localparam logic [1:0] SEL_CSR0 = 2'd0;
	localparam logic [1:0] SEL_CSR1 = 2'd1;
	localparam logic [1:0] SEL_CSR2 = 2'd2;
	localparam logic [1:0] SEL_CSR3 = 2'd3;

	// completion outcome
	localparam logic [1:0] OC_OK       = 2'd0;
	localparam logic [1:0] OC_FRAME    = 2'd1;
	localparam logic [1:0] OC_DESC_ERR = 2'd2;
	localparam logic [1:0] OC_NO_DESC  = 2'd3;

	// event counter slots
	localparam int unsigned CNT_RX_FRAME = 0;
	localparam int unsigned CNT_TX_FRAME = 1;
	localparam int unsigned CNT_RX_ERR   = 2;
	localparam int unsigned CNT_TX_ERR   = 3;
	localparam int unsigned CNT_NUM      = 4;

endpackage

### rtl/lance_csr_interrupt_block.sv
// ----------------------------------------------------------------------------
// lance_csr_interrupt_block: LANCE-style register port and interrupt logic
// Handles RAP/RDP/RST bus writes, CSR0 control, init/rx/tx completion
// events, interrupt level and edge reporting, and frame/error counters.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ stream carries one request per beat: the kind (bus write, init,
//   receive or transmit completion, bus init reset) in s_tuser, the bus
//   register target, write data and completion outcome in s_tdata.
//   Each request yields exactly one beat on the m_ stream: RDP and RAP read
//   values, interrupt level, raise/cancel edges, the init block request
//   and address, and the four wrapping event counters.
//   A request passes through an input register, then one pass of update
//   logic writes the CSR state and the result register. Throughput is one
//   request per cycle while the receiver takes results.
//   When the receiver stalls, the result register holds, the input
//   register fills, and s_tready drops until the result is taken.
//   Reset puts CSR0 at STOP, clears CSR1-3, RAP, the counters and the
//   interrupt history, and empties both registers.
// ----------------------------------------------------------------------------
module lance_csr_interrupt_block
	import lcib_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [1:0] reg_index, [17:2] write_data, [19:18] outcome, [23:20] zero
	input  logic [23:0]  s_tdata,
	// [2:0] func
	input  logic [2:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [15:0] rdp_value, [17:16] rap_value, [18] irq_level, [19] irq_raise,
	// [20] irq_cancel, [21] init_request, [53:22] init_address,
	// [85:54] rx_frame_count, [117:86] tx_frame_count,
	// [149:118] rx_error_count, [181:150] tx_error_count, [183:182] zero
	output logic [183:0] m_tdata
);

	// input register
	logic        valid_s1;
	logic [2:0]  func_s1;
	logic [1:0]  reg_s1;
	csr_t        data_s1;
	logic [1:0]  oc_s1;

	// CSR state
	csr_t        csr0_q, csr1_q, csr2_q, csr3_q;
	logic [1:0]  rap_q;
	logic        running_q, init_ok_q, irq_last_q;
	count_t      cnt_q [CNT_NUM];

	// next state
	csr_t        csr0_d, csr1_d, csr2_d, csr3_d;
	logic [1:0]  rap_d;
	logic        running_d, init_ok_d, irq_last_d;
	count_t      cnt_d [CNT_NUM];
	logic        req_d, no_edge_d, lvl_d, raise_d, cancel_d;
	logic [31:0] addr_d;
	csr_t        rdp_d;

	logic        advance;

	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1 <= s_tuser;
			reg_s1  <= s_tdata[1:0];
			data_s1 <= s_tdata[17:2];
			oc_s1   <= s_tdata[19:18];
		end
	end

	always_comb begin
		csr0_d      = csr0_q;
		csr1_d      = csr1_q;
		csr2_d      = csr2_q;
		csr3_d      = csr3_q;
		rap_d       = rap_q;
		running_d   = running_q;
		init_ok_d   = init_ok_q;
		irq_last_d  = irq_last_q;
		cnt_d       = cnt_q;
		req_d       = 1'b0;
		addr_d      = '0;
		no_edge_d   = 1'b0;

		unique case (func_s1)
			FN_BUS_WRITE: begin
				unique case (reg_s1)
					REG_RDP: begin
						unique case (rap_q)
							SEL_CSR0: begin
								if (data_s1[CSR0_STOP]) begin
									running_d = 1'b0;
									csr0_d[CSR0_STRT] = 1'b0;
									csr0_d[CSR0_INIT] = 1'b0;
									csr0_d[CSR0_TDMD] = 1'b0;
									csr0_d[CSR0_RXON] = 1'b0;
									csr0_d[CSR0_TXON] = 1'b0;
									csr0_d[CSR0_INTR] = 1'b0;
									csr0_d = csr0_d & ~CSR0_W1C_MASK;
									csr0_d[CSR0_STOP] = 1'b1;
								end
								if (data_s1[CSR0_INIT]) begin
									running_d   = 1'b0;
									init_ok_d   = 1'b0;
									csr0_d[CSR0_STRT] = 1'b0;
									csr0_d[CSR0_TDMD] = 1'b0;
									csr0_d[CSR0_RXON] = 1'b0;
									csr0_d[CSR0_TXON] = 1'b0;
									csr0_d[CSR0_INTR] = 1'b0;
									csr0_d[CSR0_INIT] = 1'b1;
									req_d  = 1'b1;
									addr_d = {csr2_q[14:0], csr1_q, 1'b0};
								end
								if (data_s1[CSR0_STRT]) begin
									// start needs a finished init, pending init included
									if (!init_ok_d) begin
										csr0_d[CSR0_ERR] = 1'b1;
									end else begin
										running_d = 1'b1;
										csr0_d[CSR0_STOP] = 1'b0;
										csr0_d[CSR0_INIT] = 1'b0;
										csr0_d[CSR0_TDMD] = 1'b0;
										csr0_d[CSR0_STRT] = 1'b1;
										csr0_d[CSR0_RXON] = 1'b1;
										csr0_d[CSR0_TXON] = 1'b1;
									end
								end
								csr0_d[CSR0_INEA] = data_s1[CSR0_INEA];
								csr0_d = csr0_d & ~(data_s1 & CSR0_W1C_MASK);
							end
							SEL_CSR1: csr1_d = data_s1;
							SEL_CSR2: csr2_d = data_s1;
							SEL_CSR3: csr3_d = data_s1;
							default:  csr3_d = data_s1;
						endcase
					end
					REG_RAP: rap_d = data_s1[1:0];
					REG_RST: begin
						// stop and clear everything, keep level history for the edge
						csr0_d      = CSR0_RESET;
						csr1_d      = '0;
						csr2_d      = '0;
						csr3_d      = '0;
						rap_d       = SEL_CSR0;
						running_d   = 1'b0;
						init_ok_d   = 1'b0;
						for (int i = 0; i < CNT_NUM; i++) begin
							cnt_d[i] = '0;
						end
					end
					default: ;
				endcase
			end
			FN_INIT_DONE: begin
				if (csr0_q[CSR0_INIT]) begin
					if (oc_s1 == OC_OK) begin
						init_ok_d = 1'b1;
						csr0_d[CSR0_INIT] = 1'b0;
						csr0_d[CSR0_IDON] = 1'b1;
					end else begin
						csr0_d[CSR0_ERR] = 1'b1;
					end
				end
			end
			FN_RX_DONE: begin
				if (running_q && init_ok_q) begin
					csr0_d[CSR0_RINT] = 1'b1;
					case (oc_s1)
						OC_OK: cnt_d[CNT_RX_FRAME] = cnt_q[CNT_RX_FRAME] + 32'd1;
						OC_DESC_ERR: csr0_d[CSR0_ERR] = 1'b1;
						default: begin
							csr0_d[CSR0_ERR] = 1'b1;
							cnt_d[CNT_RX_ERR] = cnt_q[CNT_RX_ERR] + 32'd1;
						end
					endcase
				end
			end
			FN_TX_DONE: begin
				if (running_q && init_ok_q) begin
					case (oc_s1)
						OC_OK: begin
							csr0_d[CSR0_TINT] = 1'b1;
							cnt_d[CNT_TX_FRAME] = cnt_q[CNT_TX_FRAME] + 32'd1;
						end
						OC_FRAME: begin
							csr0_d[CSR0_TINT] = 1'b1;
							csr0_d[CSR0_ERR]  = 1'b1;
							cnt_d[CNT_TX_ERR] = cnt_q[CNT_TX_ERR] + 32'd1;
						end
						OC_DESC_ERR: begin
							csr0_d[CSR0_TINT] = 1'b1;
							csr0_d[CSR0_ERR]  = 1'b1;
						end
						default: ;
					endcase
				end
			end
			FN_BUS_RESET: begin
				csr0_d      = CSR0_RESET;
				csr1_d      = '0;
				csr2_d      = '0;
				csr3_d      = '0;
				rap_d       = SEL_CSR0;
				running_d   = 1'b0;
				init_ok_d   = 1'b0;
				for (int i = 0; i < CNT_NUM; i++) begin
					cnt_d[i] = '0;
				end
				no_edge_d = 1'b1;
			end
			default: ;
		endcase

		lvl_d = csr0_d[CSR0_INEA] && (|(csr0_d & CSR0_W1C_MASK));
		csr0_d[CSR0_INTR] = lvl_d;
		raise_d  = !no_edge_d && lvl_d && !irq_last_q;
		cancel_d = !no_edge_d && !lvl_d && irq_last_q;
		irq_last_d = lvl_d;

		unique case (rap_d)
			SEL_CSR0: rdp_d = csr0_d;
			SEL_CSR1: rdp_d = csr1_d;
			SEL_CSR2: rdp_d = csr2_d;
			SEL_CSR3: rdp_d = csr3_d;
			default:  rdp_d = csr3_d;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			csr0_q      <= CSR0_RESET;
			csr1_q      <= '0;
			csr2_q      <= '0;
			csr3_q      <= '0;
			rap_q       <= SEL_CSR0;
			running_q   <= 1'b0;
			init_ok_q   <= 1'b0;
			irq_last_q  <= 1'b0;
			for (int i = 0; i < CNT_NUM; i++) begin
				cnt_q[i] <= '0;
			end
			m_tvalid    <= 1'b0;
		end else begin
			if (advance) begin
				csr0_q      <= csr0_d;
				csr1_q      <= csr1_d;
				csr2_q      <= csr2_d;
				csr3_q      <= csr3_d;
				rap_q       <= rap_d;
				running_q   <= running_d;
				init_ok_q   <= init_ok_d;
				irq_last_q  <= irq_last_d;
				cnt_q       <= cnt_d;
				m_tvalid    <= 1'b1;
			end else if (m_tready) begin
				m_tvalid    <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata <= {2'b00,
				cnt_d[CNT_TX_ERR], cnt_d[CNT_RX_ERR],
				cnt_d[CNT_TX_FRAME], cnt_d[CNT_RX_FRAME],
				addr_d, req_d, cancel_d, raise_d, lvl_d, rap_d, rdp_d};
		end
	end

endmodule

### dv/lcib_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcib_result_checker: result predictor and comparator for the CSR block
// Watches both streams, models CSR0-3, RAP, run/init state, the interrupt
// level history and the four event counters, and compares every result
// beat field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module lcib_result_checker
	import lcib_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	// [1:0] reg_index, [17:2] write_data, [19:18] outcome, [23:20] zero
	input  logic [23:0]  s_tdata,
	// [2:0] func
	input  logic [2:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	// [15:0] rdp_value, [17:16] rap_value, [18] irq_level, [19] irq_raise,
	// [20] irq_cancel, [21] init_request, [53:22] init_address,
	// [85:54] rx_frame_count, [117:86] tx_frame_count,
	// [149:118] rx_error_count, [181:150] tx_error_count, [183:182] zero
	input  logic [183:0] m_tdata,
	output int           mismatches,
	output int           waiting,
	output int           compared
);

	localparam csr_t M_ERR  = csr_t'(1) << CSR0_ERR;
	localparam csr_t M_RINT = csr_t'(1) << CSR0_RINT;
	localparam csr_t M_TINT = csr_t'(1) << CSR0_TINT;
	localparam csr_t M_IDON = csr_t'(1) << CSR0_IDON;
	localparam csr_t M_INTR = csr_t'(1) << CSR0_INTR;
	localparam csr_t M_RXON = csr_t'(1) << CSR0_RXON;
	localparam csr_t M_TXON = csr_t'(1) << CSR0_TXON;
	localparam csr_t M_TDMD = csr_t'(1) << CSR0_TDMD;
	localparam csr_t M_STOP = csr_t'(1) << CSR0_STOP;
	localparam csr_t M_STRT = csr_t'(1) << CSR0_STRT;
	localparam csr_t M_INIT = csr_t'(1) << CSR0_INIT;

	// same layout as m_tdata[181:0]
	typedef struct packed {
		count_t      tx_errs;
		count_t      rx_errs;
		count_t      tx_good;
		count_t      rx_good;
		logic [31:0] boot_addr;
		logic        init_req;
		logic        irq_cancel;
		logic        irq_raise;
		logic        irq_level;
		logic [1:0]  rap;
		csr_t        rdp;
	} csr_result_t;

	csr_t        csr0;
	csr_t        init_low;
	csr_t        init_high;
	csr_t        spare;
	logic [1:0]  rap_sel;
	logic        running;
	logic        init_ok;
	logic        prev_level;
	count_t      tally [CNT_NUM];

	csr_result_t result_q [$];
	csr_result_t predicted;
	csr_result_t wanted;
	csr_result_t seen;

	task automatic clear_state();
		csr0 = CSR0_RESET;
		init_low = '0;
		init_high = '0;
		spare = '0;
		rap_sel = SEL_CSR0;
		running = 1'b0;
		init_ok = 1'b0;
		prev_level = 1'b0;
		for (int i = 0; i < CNT_NUM; i++)
			tally[i] = '0;
	endtask

	task automatic predict_result(input logic [2:0] fn, input logic [1:0] tgt,
			input csr_t wd, input logic [1:0] oc, output csr_result_t r);
		logic quiet_edges;
		logic level;
		logic was;
		logic rx;
		csr_t ibit;
		r = '0;
		quiet_edges = 1'b0;
		case (fn)
			FN_BUS_WRITE: begin
				case (tgt)
					REG_RDP: begin
						case (rap_sel)
							SEL_CSR0: begin
								if (wd & M_STOP) begin
									running = 1'b0;
									csr0 &= ~(M_STRT | M_INIT | M_TDMD | M_RXON | M_TXON);
									csr0 |= M_STOP;
									csr0 &= ~(M_IDON | M_TINT | M_RINT | M_ERR | M_INTR);
								end
								if (wd & M_INIT) begin
									running = 1'b0;
									init_ok = 1'b0;
									csr0 &= ~(M_STRT | M_TDMD | M_RXON | M_TXON | M_INTR);
									csr0 |= M_INIT;
									r.init_req = 1'b1;
									r.boot_addr = {init_high, init_low} << 1;
								end
								// start without a finished init only flags an error
								if (wd & M_STRT) begin
									if (!init_ok) begin
										csr0 |= M_ERR;
									end else begin
										running = 1'b1;
										csr0 &= ~(M_STOP | M_INIT | M_TDMD);
										csr0 |= M_STRT | M_RXON | M_TXON;
									end
								end
								csr0[CSR0_INEA] = wd[CSR0_INEA];
								csr0 &= ~(wd & CSR0_W1C_MASK);
							end
							SEL_CSR1: init_low = wd;
							SEL_CSR2: init_high = wd;
							default: spare = wd;
						endcase
					end
					REG_RAP: rap_sel = wd[1:0];
					REG_RST: begin
						was = prev_level;
						clear_state();
						prev_level = was;
					end
					default: ;
				endcase
			end
			FN_INIT_DONE: begin
				if (csr0 & M_INIT) begin
					if (oc == OC_OK) begin
						init_ok = 1'b1;
						csr0 &= ~M_INIT;
						csr0 |= M_IDON;
					end else begin
						csr0 |= M_ERR;
					end
				end
			end
			FN_RX_DONE, FN_TX_DONE: begin
				if (running && init_ok) begin
					rx = (fn == FN_RX_DONE);
					ibit = rx ? M_RINT : M_TINT;
					case (oc)
						OC_OK: begin
							csr0 |= ibit;
							if (rx) tally[CNT_RX_FRAME]++;
							else tally[CNT_TX_FRAME]++;
						end
						OC_FRAME: begin
							csr0 |= ibit | M_ERR;
							if (rx) tally[CNT_RX_ERR]++;
							else tally[CNT_TX_ERR]++;
						end
						OC_DESC_ERR: csr0 |= ibit | M_ERR;
						default: begin
							// missing descriptor matters on receive only
							if (rx) begin
								csr0 |= ibit | M_ERR;
								tally[CNT_RX_ERR]++;
							end
						end
					endcase
				end
			end
			FN_BUS_RESET: begin
				clear_state();
				quiet_edges = 1'b1;
			end
			default: ;
		endcase

		level = csr0[CSR0_INEA] && ((csr0 & CSR0_W1C_MASK) != '0);
		csr0[CSR0_INTR] = level;
		r.irq_level = level;
		r.irq_raise = !quiet_edges && level && !prev_level;
		r.irq_cancel = !quiet_edges && !level && prev_level;
		prev_level = level;

		case (rap_sel)
			SEL_CSR0: r.rdp = csr0;
			SEL_CSR1: r.rdp = init_low;
			SEL_CSR2: r.rdp = init_high;
			default: r.rdp = spare;
		endcase
		r.rap = rap_sel;
		r.rx_good = tally[CNT_RX_FRAME];
		r.tx_good = tally[CNT_TX_FRAME];
		r.rx_errs = tally[CNT_RX_ERR];
		r.tx_errs = tally[CNT_TX_ERR];
	endtask

	task automatic check_field(input string what, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what,
				exp_val, act_val);
			mismatches++;
		end
	endtask

	task automatic compare_result(input csr_result_t e, input csr_result_t a);
		check_field("rdp_value", 32'(e.rdp), 32'(a.rdp));
		check_field("rap_value", 32'(e.rap), 32'(a.rap));
		check_field("irq_level", 32'(e.irq_level), 32'(a.irq_level));
		check_field("irq_raise", 32'(e.irq_raise), 32'(a.irq_raise));
		check_field("irq_cancel", 32'(e.irq_cancel), 32'(a.irq_cancel));
		check_field("init_request", 32'(e.init_req), 32'(a.init_req));
		check_field("init_address", e.boot_addr, a.boot_addr);
		check_field("rx_frame_count", e.rx_good, a.rx_good);
		check_field("tx_frame_count", e.tx_good, a.tx_good);
		check_field("rx_error_count", e.rx_errs, a.rx_errs);
		check_field("tx_error_count", e.tx_errs, a.tx_errs);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
			result_q.delete();
			mismatches = 0;
			compared = 0;
			waiting = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_result(s_tuser, s_tdata[1:0], s_tdata[17:2], s_tdata[19:18],
					predicted);
				result_q.push_back(predicted);
			end
			if (m_tvalid && m_tready) begin
				seen = csr_result_t'(m_tdata[181:0]);
				if (result_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time,
						m_tdata);
					mismatches++;
				end else begin
					wanted = result_q.pop_front();
					compare_result(wanted, seen);
					compared++;
				end
			end
			waiting = result_q.size();
		end
	end

endmodule

### dv/lance_csr_interrupt_block_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lance_csr_interrupt_block_test: stimulus and verdict for the CSR block
// Drives directed register and event requests, then random bring-up,
// traffic and noise requests with random gaps and output stalls, including
// one long stall that backs the block up. Results are checked on the side.
// ----------------------------------------------------------------------------
module lance_csr_interrupt_block_test;
	import lcib_pkg::*;

	localparam int   TOTAL_REQS  = 1350;
	localparam int   LONG_STALL  = 80;
	localparam logic [1:0] REG_NONE = 2'd3;

	localparam csr_t M_ERR  = csr_t'(1) << CSR0_ERR;
	localparam csr_t M_INEA = csr_t'(1) << CSR0_INEA;
	localparam csr_t M_STOP = csr_t'(1) << CSR0_STOP;
	localparam csr_t M_STRT = csr_t'(1) << CSR0_STRT;
	localparam csr_t M_INIT = csr_t'(1) << CSR0_INIT;

	logic         clk;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [23:0]  s_tdata = '0;
	logic [2:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [183:0] m_tdata;

	int mismatches;
	int waiting;
	int compared;
	int sent_total = 0;
	int kind_count [8];
	bit steady = 1'b0;
	bit stall_done = 1'b0;

	lance_csr_interrupt_block dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	lcib_result_checker u_results (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.mismatches (mismatches),
		.waiting    (waiting),
		.compared   (compared)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("Verification failed");
		$finish;
	end

	// receiver: random stalls, one long hold-off once traffic is flowing
	initial begin
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (!stall_done && sent_total >= 300) begin
				hold = LONG_STALL;
				stall_done = 1'b1;
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= steady || ($urandom_range(99) >= 12);
			end
		end
	end

	task automatic issue(input logic [2:0] fn, input logic [1:0] tgt, input csr_t wd,
			input logic [1:0] oc);
		while (!steady && $urandom_range(99) < 12) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tuser <= fn;
		s_tdata <= {4'b0, oc, wd, tgt};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		kind_count[fn]++;
		sent_total++;
		steady = (sent_total >= 600 && sent_total < 800);
	endtask

	// program the init block address, init, then start
	task automatic bring_up();
		csr_t ie;
		ie = ($urandom_range(99) < 75) ? M_INEA : '0;
		issue(FN_BUS_WRITE, REG_RAP, {14'($urandom), SEL_CSR1}, 2'($urandom));
		issue(FN_BUS_WRITE, REG_RDP, 16'($urandom), 2'($urandom));
		issue(FN_BUS_WRITE, REG_RAP, {14'($urandom), SEL_CSR2}, 2'($urandom));
		issue(FN_BUS_WRITE, REG_RDP, ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom),
			2'($urandom));
		issue(FN_BUS_WRITE, REG_RAP, {14'($urandom), SEL_CSR0}, 2'($urandom));
		issue(FN_BUS_WRITE, REG_RDP, M_INIT | ie | (($urandom_range(3) == 0) ? M_STOP : '0),
			2'($urandom));
		if ($urandom_range(99) < 20)
			issue(FN_INIT_DONE, 2'($urandom), 16'($urandom), 2'($urandom_range(3, 1)));
		issue(FN_INIT_DONE, 2'($urandom), 16'($urandom), OC_OK);
		issue(FN_BUS_WRITE, REG_RDP, M_STRT | ie, 2'($urandom));
	endtask

	task automatic traffic_burst();
		int n;
		int r;
		logic [1:0] oc;
		n = $urandom_range(12, 4);
		repeat (n) begin
			r = $urandom_range(99);
			oc = ($urandom_range(99) < 55) ? OC_OK : 2'($urandom);
			if (r < 80)
				issue($urandom_range(1) ? FN_RX_DONE : FN_TX_DONE, 2'($urandom),
					16'($urandom), oc);
			else if (r < 92)
				issue(FN_BUS_WRITE, REG_RDP, 16'($urandom) & (CSR0_W1C_MASK | M_INEA),
					2'($urandom));
			else
				issue(FN_BUS_WRITE, REG_RAP, 16'($urandom), 2'($urandom));
		end
	endtask

	initial begin
		int r;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unused kinds and target change nothing
		for (int k = 1; k <= 3; k++)
			issue(FN_BUS_RESET + 3'(k), 2'b11, 16'hFFFF, 2'b11);
		issue(FN_BUS_WRITE, REG_NONE, 16'hFFFF, OC_OK);
		issue(FN_BUS_WRITE, REG_RAP, {14'h3FFF, SEL_CSR0}, OC_NO_DESC);
		// start before init, then clear the error
		issue(FN_BUS_WRITE, REG_RDP, M_STRT | M_INEA, OC_OK);
		issue(FN_BUS_WRITE, REG_RDP, M_ERR | M_INEA, OC_OK);
		// widest init block address
		issue(FN_BUS_WRITE, REG_RAP, {14'h0, SEL_CSR1}, OC_OK);
		issue(FN_BUS_WRITE, REG_RDP, 16'hFFFF, OC_OK);
		issue(FN_BUS_WRITE, REG_RAP, {14'h0, SEL_CSR2}, OC_OK);
		issue(FN_BUS_WRITE, REG_RDP, 16'hFFFF, OC_OK);
		issue(FN_BUS_WRITE, REG_RAP, {14'h0, SEL_CSR0}, OC_OK);
		// init and start in one write: start sees the pending init
		issue(FN_BUS_WRITE, REG_RDP, M_INIT | M_STRT | M_INEA, OC_OK);
		issue(FN_INIT_DONE, REG_RDP, 16'h0000, OC_FRAME);
		issue(FN_INIT_DONE, REG_RDP, 16'h0000, OC_OK);
		issue(FN_INIT_DONE, REG_RDP, 16'h0000, OC_OK);
		issue(FN_BUS_WRITE, REG_RDP, M_STRT | M_INEA | CSR0_W1C_MASK, OC_OK);
		for (int k = 0; k < 4; k++)
			issue(FN_RX_DONE, REG_RDP, 16'h0000, 2'(k));
		for (int k = 0; k < 4; k++)
			issue(FN_TX_DONE, REG_RDP, 16'h0000, 2'(k));
		// RST with the level high, then a bus reset
		issue(FN_BUS_WRITE, REG_RST, 16'($urandom), OC_OK);
		issue(FN_BUS_RESET, REG_RDP, 16'h0000, OC_OK);

		while (sent_total < TOTAL_REQS) begin
			r = $urandom_range(99);
			if (r < 8)
				issue(3'($urandom), 2'($urandom), 16'($urandom), 2'($urandom));
			else if (r < 10)
				issue(FN_BUS_WRITE, REG_RST, 16'($urandom), 2'($urandom));
			else if (r < 22)
				bring_up();
			else
				traffic_burst();
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("Covered %0d requests: %0d bus writes, %0d init, %0d rx, %0d tx events",
			sent_total, kind_count[FN_BUS_WRITE], kind_count[FN_INIT_DONE],
			kind_count[FN_RX_DONE], kind_count[FN_TX_DONE]);
		$display("%0d bus resets, %0d unused kinds, %0d results compared, %0d-cycle stall",
			kind_count[FN_BUS_RESET], kind_count[5] + kind_count[6] + kind_count[7],
			compared, LONG_STALL);
		if (waiting != 0)
			$display("%0t: %0d results never arrived", $time, waiting);
		if (mismatches == 0 && waiting == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
